// ===== hw/rtl/eps_pkg.sv =====
// Shared widths, register codes, reset values, types and helpers of the position servo.
package eps_pkg;

    localparam int COUNT_BITS = 32;
    localparam int DUTY_BITS  = 11;

    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 17;
    localparam int LEVEL_W  = 11;
    localparam int DPC_W    = 24;
    localparam int ANGLE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = ((2 + ANGLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * DUTY_BITS + 7) / 8) * 8;

    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 24;
    localparam int MUL_H_W   = MUL_A_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int ERR_W     = ANGLE_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int P_W       = ERR_W + GAIN_W - 8;
    localparam int DTERM_W   = DIFF_W + GAIN_W - 8;
    localparam int INTEG_W   = 32;
    localparam int ISUM_W    = P_W + 1;
    localparam int CTL_SUM_W = DTERM_W + 2;
    localparam int CTL_W     = 18;
    localparam int CTL_LIMIT = 65536;
    localparam int SPAN_W    = LEVEL_W + 1;
    localparam int DUTY_W    = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEG_PER_COUNT = 3'd6;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 16'd4588;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN    = 16'd492;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 16'd4260;
    localparam logic [BAND_W-1:0]  RST_DEAD_BAND     = 17'd6554;
    localparam logic [LEVEL_W-1:0] RST_DUTY_FLOOR    = 11'd675;
    localparam logic [LEVEL_W-1:0] RST_DUTY_CEILING  = 11'd1024;
    localparam logic [DPC_W-1:0]   RST_DEG_PER_COUNT = 24'd1266737;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [BAND_W-1:0]  dead_band;
        logic [LEVEL_W-1:0] duty_floor;
        logic [LEVEL_W-1:0] duty_ceiling;
        logic [DPC_W-1:0]   deg_per_count;
    } cfg_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic                 valid;
        logic [DUTY_BITS-1:0] fwd_duty;
        logic [DUTY_BITS-1:0] rev_duty;
        logic                 coasting;
    } res_t;

    // Round half up: floor((v + 2^(s-1)) / 2^s).
    function automatic logic signed [MUL_P_W-1:0] round_shr(
        input logic signed [MUL_P_W-1:0] v,
        input int unsigned               s
    );
        logic signed [MUL_P_W-1:0] bias;
        bias = '0;
        bias[s-1] = 1'b1;
        return (v + bias) >>> s;
    endfunction

endpackage

// ===== hw/rtl/eps_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier, one bit a cycle.
module eps_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  eps_pkg::mul_req_t req,
    output eps_pkg::mul_rsp_t rsp
);

    logic signed [eps_pkg::MUL_A_W-1:0] a_reg;
    logic [eps_pkg::MUL_B_W-1:0]        b_reg;
    logic signed [eps_pkg::MUL_H_W-1:0] hi_reg;
    logic signed [eps_pkg::MUL_H_W-1:0] hi_next;
    logic [eps_pkg::MUL_B_W-1:0]        lo_reg;
    logic [eps_pkg::MUL_B_W-1:0]        lo_next;
    logic [eps_pkg::MUL_CNT_W-1:0]      cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [eps_pkg::MUL_H_W-1:0] addend;
    logic signed [eps_pkg::MUL_H_W-1:0] sum;

    always_comb
    begin
        addend  = b_reg[0] ? eps_pkg::MUL_H_W'(a_reg) : '0;
        sum     = hi_reg + addend;
        hi_next = sum >>> 1;
        lo_next = {sum[0], lo_reg[eps_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            b_reg  <= req.b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= b_reg >> 1;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == eps_pkg::MUL_CNT_W'(eps_pkg::MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg[eps_pkg::MUL_A_W-1:0], lo_reg};

endmodule

// ===== hw/rtl/eps_seq.sv =====
// Control tick sequencer: position conversion, PID terms and duty mapping over the multiplier.
module eps_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [eps_pkg::COUNT_BITS-1:0] count,
    input  logic [eps_pkg::ANGLE_W-1:0]    target,
    input  eps_pkg::cfg_t                  cfg,
    output logic                           idle,
    output eps_pkg::res_t                  res,
    input  logic                           res_take,
    output eps_pkg::mul_req_t              mul_req,
    input  eps_pkg::mul_rsp_t              mul_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POS_W = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_P_GO  = 4'd3;
    localparam logic [3:0] S_P_W   = 4'd4;
    localparam logic [3:0] S_I_W   = 4'd5;
    localparam logic [3:0] S_I_ACC = 4'd6;
    localparam logic [3:0] S_D_W   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_EVAL  = 4'd9;
    localparam logic [3:0] S_U_W   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [eps_pkg::ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(eps_pkg::ANGLE_W-1){1'b1}}};
    localparam logic [eps_pkg::ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(eps_pkg::ANGLE_W-1){1'b0}}};
    localparam logic [eps_pkg::INTEG_W-1:0] INTEG_MAX = {1'b0, {(eps_pkg::INTEG_W-1){1'b1}}};
    localparam logic [eps_pkg::INTEG_W-1:0] INTEG_MIN = {1'b1, {(eps_pkg::INTEG_W-1){1'b0}}};
    localparam logic signed [eps_pkg::CTL_SUM_W-1:0] CTL_HI =
        eps_pkg::CTL_SUM_W'(eps_pkg::CTL_LIMIT);
    localparam logic signed [eps_pkg::CTL_SUM_W-1:0] CTL_LO = -CTL_HI;

    logic [3:0]                             state_reg;
    logic [3:0]                             state_next;
    logic signed [eps_pkg::ANGLE_W-1:0]     target_reg;
    logic signed [eps_pkg::ANGLE_W-1:0]     pos_reg;
    logic signed [eps_pkg::ERR_W-1:0]       err_reg;
    logic signed [eps_pkg::ERR_W-1:0]       prev_reg;
    logic signed [eps_pkg::P_W-1:0]         p_reg;
    logic signed [eps_pkg::P_W-1:0]         iv_reg;
    logic signed [eps_pkg::INTEG_W-1:0]     integ_reg;
    logic signed [eps_pkg::DTERM_W-1:0]     d_reg;
    logic signed [eps_pkg::CTL_W-1:0]       ctl_reg;
    logic                                   drive_rev_reg;
    logic [eps_pkg::DUTY_BITS-1:0]          fwd_reg;
    logic [eps_pkg::DUTY_BITS-1:0]          rev_reg;
    logic                                   coast_reg;

    logic signed [eps_pkg::MUL_P_W-1:0]     r16;
    logic signed [eps_pkg::MUL_P_W-1:0]     r8;
    logic [eps_pkg::MUL_P_W-eps_pkg::ANGLE_W:0] pos_top;
    logic signed [eps_pkg::ANGLE_W-1:0]     pos_sat;
    logic signed [eps_pkg::DIFF_W-1:0]      diff;
    logic signed [eps_pkg::ISUM_W-1:0]      isum;
    logic signed [eps_pkg::CTL_SUM_W-1:0]   ctl_sum;
    logic signed [eps_pkg::CTL_W-1:0]       ctl_neg;
    logic [eps_pkg::BAND_W-1:0]             mag;
    logic                                   coast;
    logic signed [eps_pkg::SPAN_W-1:0]      span;
    logic [eps_pkg::DUTY_W-1:0]             duty;

    always_comb
    begin
        r16 = eps_pkg::round_shr(mul_rsp.prod, 16);
        r8  = eps_pkg::round_shr(mul_rsp.prod, 8);

        // Saturate degrees to the angle range.
        pos_top = r16[eps_pkg::MUL_P_W-1:eps_pkg::ANGLE_W-1];
        if ((&pos_top) || !(|pos_top))
            pos_sat = r16[eps_pkg::ANGLE_W-1:0];
        else if (r16[eps_pkg::MUL_P_W-1])
            pos_sat = ANGLE_MIN;
        else
            pos_sat = ANGLE_MAX;

        diff    = eps_pkg::DIFF_W'(err_reg) - eps_pkg::DIFF_W'(prev_reg);
        isum    = eps_pkg::ISUM_W'(integ_reg) + eps_pkg::ISUM_W'(iv_reg);
        ctl_sum = eps_pkg::CTL_SUM_W'(p_reg) + eps_pkg::CTL_SUM_W'(integ_reg)
                + eps_pkg::CTL_SUM_W'(d_reg);

        ctl_neg = -ctl_reg;
        mag     = ctl_reg[eps_pkg::CTL_W-1] ? ctl_neg[eps_pkg::BAND_W-1:0]
                                            : ctl_reg[eps_pkg::BAND_W-1:0];
        coast   = mag < cfg.dead_band;
        span    = eps_pkg::SPAN_W'({1'b0, cfg.duty_ceiling})
                - eps_pkg::SPAN_W'({1'b0, cfg.duty_floor});
        duty    = eps_pkg::DUTY_W'(cfg.duty_floor) + r16[eps_pkg::DUTY_W-1:0];
    end

    // Multiplier launches.
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = eps_pkg::MUL_A_W'(err_reg);
        mul_req.b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_req.start = start;
                mul_req.a     = eps_pkg::MUL_A_W'(signed'(count));
                mul_req.b     = eps_pkg::MUL_B_W'(cfg.deg_per_count);
            end
            S_P_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.b     = eps_pkg::MUL_B_W'(cfg.prop_gain);
            end
            S_P_W:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.b     = eps_pkg::MUL_B_W'(cfg.integ_gain);
            end
            S_I_W:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = eps_pkg::MUL_A_W'(diff);
                mul_req.b     = eps_pkg::MUL_B_W'(cfg.deriv_gain);
            end
            S_EVAL:
            begin
                mul_req.start = !coast;
                mul_req.a     = eps_pkg::MUL_A_W'(span);
                mul_req.b     = eps_pkg::MUL_B_W'(mag);
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_POS_W;
            S_POS_W: if (mul_rsp.done) state_next = S_ERR;
            S_ERR:   state_next = S_P_GO;
            S_P_GO:  state_next = S_P_W;
            S_P_W:   if (mul_rsp.done) state_next = S_I_W;
            S_I_W:   if (mul_rsp.done) state_next = S_I_ACC;
            S_I_ACC: state_next = S_D_W;
            S_D_W:   if (mul_rsp.done) state_next = S_SUM;
            S_SUM:   state_next = S_EVAL;
            S_EVAL:  state_next = coast ? S_OUT : S_U_W;
            S_U_W:   if (mul_rsp.done) state_next = S_OUT;
            S_OUT:   if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_I_W && mul_rsp.done)
                prev_reg <= err_reg;
            if (state_reg == S_I_ACC)
            begin
                if (isum[eps_pkg::ISUM_W-1:eps_pkg::INTEG_W-1] == '0
                    || (&isum[eps_pkg::ISUM_W-1:eps_pkg::INTEG_W-1]))
                    integ_reg <= isum[eps_pkg::INTEG_W-1:0];
                else if (isum[eps_pkg::ISUM_W-1])
                    integ_reg <= INTEG_MIN;
                else
                    integ_reg <= INTEG_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    target_reg <= target;
            end
            S_POS_W:
            begin
                if (mul_rsp.done)
                    pos_reg <= pos_sat;
            end
            S_ERR:
            begin
                err_reg <= eps_pkg::ERR_W'(pos_reg) - eps_pkg::ERR_W'(target_reg);
            end
            S_P_W:
            begin
                if (mul_rsp.done)
                    p_reg <= r8[eps_pkg::P_W-1:0];
            end
            S_I_W:
            begin
                if (mul_rsp.done)
                    iv_reg <= r8[eps_pkg::P_W-1:0];
            end
            S_D_W:
            begin
                if (mul_rsp.done)
                    d_reg <= r8[eps_pkg::DTERM_W-1:0];
            end
            S_SUM:
            begin
                if (ctl_sum > CTL_HI)
                    ctl_reg <= CTL_HI[eps_pkg::CTL_W-1:0];
                else if (ctl_sum < CTL_LO)
                    ctl_reg <= CTL_LO[eps_pkg::CTL_W-1:0];
                else
                    ctl_reg <= ctl_sum[eps_pkg::CTL_W-1:0];
            end
            S_EVAL:
            begin
                // Positive control drives the reverse channel.
                drive_rev_reg <= !ctl_reg[eps_pkg::CTL_W-1] && (ctl_reg != '0);
                coast_reg     <= coast;
                fwd_reg       <= '0;
                rev_reg       <= '0;
            end
            S_U_W:
            begin
                if (mul_rsp.done)
                begin
                    if (drive_rev_reg)
                        rev_reg <= duty[eps_pkg::DUTY_BITS-1:0];
                    else
                        fwd_reg <= duty[eps_pkg::DUTY_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign idle         = (state_reg == S_IDLE);
    assign res.valid    = (state_reg == S_OUT);
    assign res.fwd_duty = fwd_reg;
    assign res.rev_duty = rev_reg;
    assign res.coasting = coast_reg;

endmodule

// ===== hw/rtl/encoder_pid_position_servo_unit.sv =====
// Top level of the encoder PID position servo: stream ports, registers, encoder count, output.

// Position servo for a DC motor. Each request on the input stream is either an
// encoder edge (s_tuser = 0), which moves the position count up when the A and B
// levels agree and down when they differ and gives no result, or a control tick
// (s_tuser = 1), which carries the target angle in signed Q16.8 degrees and gives
// exactly one result: the forward and reverse duties and the coast flag. The block
// holds one bit-serial multiplier, and a tick makes four passes through it (position
// in degrees, proportional, integral and derivative terms) plus a fifth for the duty
// mapping when the motor does not coast. While a tick is being worked out s_tready
// stays low. A finished result waits in the output register, so edges are taken
// while it waits; a following tick holds at the end of its work until that register
// is free. Gains and limits must be written through the cfg port only while the
// block is idle; the block itself does not enforce this. They take effect on the
// next tick.
module encoder_pid_position_servo_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // enc_a [0], enc_b [1], target_angle [25:2], zero pad above
    input  logic [eps_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind [0]
    input  logic [0:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fwd_duty [DUTY_BITS-1:0], rev_duty [2*DUTY_BITS-1:DUTY_BITS], zero pad above
    output logic [eps_pkg::OUT_TDATA_W-1:0] m_tdata,
    // coasting [0]
    output logic [0:0]                      m_tuser,

    input  logic                            cfg_we,
    input  logic [eps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eps_pkg::CFG_W-1:0]       cfg_data
);

    eps_pkg::cfg_t                  cfg_reg;
    logic [eps_pkg::COUNT_BITS-1:0] count_reg;
    logic                           m_tvalid_reg;
    logic [eps_pkg::DUTY_BITS-1:0]  fwd_reg;
    logic [eps_pkg::DUTY_BITS-1:0]  rev_reg;
    logic                           coast_reg;

    logic                           in_take;
    logic                           tick_take;
    logic                           seq_idle;
    logic                           out_free;
    logic                           res_take;
    eps_pkg::res_t                  res;
    eps_pkg::mul_req_t              mul_req;
    eps_pkg::mul_rsp_t              mul_rsp;

    // Requests enter only while the sequencer is free.
    assign s_tready  = seq_idle;
    assign in_take   = s_tvalid && s_tready;
    assign tick_take = in_take && s_tuser[0];

    // The output register frees itself in the cycle its request is taken.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign res_take  = res.valid && out_free;

    // Register file: writes past the last register drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain     <= eps_pkg::RST_PROP_GAIN;
            cfg_reg.integ_gain    <= eps_pkg::RST_INTEG_GAIN;
            cfg_reg.deriv_gain    <= eps_pkg::RST_DERIV_GAIN;
            cfg_reg.dead_band     <= eps_pkg::RST_DEAD_BAND;
            cfg_reg.duty_floor    <= eps_pkg::RST_DUTY_FLOOR;
            cfg_reg.duty_ceiling  <= eps_pkg::RST_DUTY_CEILING;
            cfg_reg.deg_per_count <= eps_pkg::RST_DEG_PER_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eps_pkg::CFG_PROP_GAIN:
                    cfg_reg.prop_gain <= cfg_data[eps_pkg::GAIN_W-1:0];
                eps_pkg::CFG_INTEG_GAIN:
                    cfg_reg.integ_gain <= cfg_data[eps_pkg::GAIN_W-1:0];
                eps_pkg::CFG_DERIV_GAIN:
                    cfg_reg.deriv_gain <= cfg_data[eps_pkg::GAIN_W-1:0];
                eps_pkg::CFG_DEAD_BAND:
                    cfg_reg.dead_band <= cfg_data[eps_pkg::BAND_W-1:0];
                eps_pkg::CFG_DUTY_FLOOR:
                    cfg_reg.duty_floor <= cfg_data[eps_pkg::LEVEL_W-1:0];
                eps_pkg::CFG_DUTY_CEILING:
                    cfg_reg.duty_ceiling <= cfg_data[eps_pkg::LEVEL_W-1:0];
                eps_pkg::CFG_DEG_PER_COUNT:
                    cfg_reg.deg_per_count <= cfg_data[eps_pkg::DPC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Quadrature count: agreeing levels advance, differing levels step back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_take && !s_tuser[0])
        begin
            if (s_tdata[0] == s_tdata[1])
                count_reg <= count_reg + 1'b1;
            else
                count_reg <= count_reg - 1'b1;
        end
    end

    eps_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    eps_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_take),
        .count    (count_reg),
        .target   (s_tdata[eps_pkg::ANGLE_W+1:2]),
        .cfg      (cfg_reg),
        .idle     (seq_idle),
        .res      (res),
        .res_take (res_take),
        .mul_req  (mul_req),
        .mul_rsp  (mul_rsp)
    );

    // Output register: hold the result until the master side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_take)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            fwd_reg   <= res.fwd_duty;
            rev_reg   <= res.rev_duty;
            coast_reg <= res.coasting;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = eps_pkg::OUT_TDATA_W'({rev_reg, fwd_reg});
    assign m_tuser  = coast_reg;

    // A coasting result never carries drive on either channel.
    a_coast_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("coasting result with nonzero duty");

    // A tick occupies the sequencer, so the next cycle takes no request.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("request taken while a tick is in progress");

    // An edge with agreeing levels advances the count by exactly one.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] && (s_tdata[0] == s_tdata[1])
        |=> count_reg == eps_pkg::COUNT_BITS'($past(count_reg) + 1'b1))
        else $error("encoder count did not advance");

    // An edge with differing levels steps the count back by exactly one.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] && (s_tdata[0] != s_tdata[1])
        |=> count_reg == eps_pkg::COUNT_BITS'($past(count_reg) - 1'b1))
        else $error("encoder count did not step back");

endmodule
